>>> rtl/sdta_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sdta_pkg
// Shared constants, types and helpers of the signed decimal to ascii unit.
// ----------------------------------------------------------------------------
package sdta_pkg;

	localparam int VALUE_BITS_DEF = 32;
	localparam int QUEUE_DEPTH    = 2;
	localparam int CNT_W          = 5;
	localparam int STEP_BITS      = 4;

	localparam logic [6:0] CHAR_NUL   = 7'h00;
	localparam logic [6:0] CHAR_ZERO  = 7'h30;
	localparam logic [6:0] CHAR_MINUS = 7'h2d;

	typedef struct packed {
		logic             err;
		logic             neg;
		logic [CNT_W-1:0] ndig;
	} job_ctrl_t;

	// decimal digits needed for a magnitude of the given bit width
	function automatic int digit_count(input int bits);
		return (bits * 30103) / 100000 + 1;
	endfunction

endpackage
`default_nettype wire

>>> rtl/sdta_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sdta_front
// Accepts an item, forms the magnitude, converts it to bcd four bits a
// cycle and classifies it (digit count, sign, capacity check).
// ----------------------------------------------------------------------------
module sdta_front #(
	parameter int VALUE_BITS = sdta_pkg::VALUE_BITS_DEF
) (
	input  wire                                             clk,
	input  wire                                             arst_n,
	input  wire                                             in_valid,
	output logic                                            in_ready,
	input  wire signed [VALUE_BITS-1:0]                     value,
	input  wire        [7:0]                                capacity,
	output logic                                            push,
	input  wire                                             full,
	output logic [sdta_pkg::digit_count(VALUE_BITS)*4-1:0]  push_bcd,
	output sdta_pkg::job_ctrl_t                             push_ctrl
);
	import sdta_pkg::*;

	localparam int DIGITS   = digit_count(VALUE_BITS);
	localparam int BCD_W    = DIGITS * 4;
	localparam int PAD_BITS = ((VALUE_BITS + STEP_BITS - 1) / STEP_BITS) * STEP_BITS;
	localparam int STEPS    = PAD_BITS / STEP_BITS;
	localparam int STEP_W   = (STEPS > 1) ? $clog2(STEPS) : 1;

	typedef enum logic [1:0] {F_IDLE, F_CONV, F_CLASS, F_PUSH} fstate_t;

	fstate_t               state_q;
	logic [STEP_W-1:0]     step_q;
	logic [PAD_BITS-1:0]   shreg_q;
	logic [BCD_W-1:0]      bcd_q;
	logic                  neg_q;
	logic [7:0]            cap_q;
	job_ctrl_t             ctrl_q;

	logic [VALUE_BITS-1:0] v_u;
	logic [VALUE_BITS-1:0] mag;
	logic [BCD_W-1:0]      bcd_n;
	logic [CNT_W-1:0]      nd;
	logic [7:0]            need;

	assign v_u = value;
	assign mag = v_u[VALUE_BITS-1] ? (~v_u + VALUE_BITS'(1)) : v_u;

	// shift-add-3 over one nibble of the magnitude
	always_comb begin
		bcd_n = bcd_q;
		for (int s = 0; s < STEP_BITS; s++) begin
			for (int d = 0; d < DIGITS; d++) begin
				if (bcd_n[d*4 +: 4] >= 4'd5) begin
					bcd_n[d*4 +: 4] = bcd_n[d*4 +: 4] + 4'd3;
				end
			end
			bcd_n = {bcd_n[BCD_W-2:0], shreg_q[PAD_BITS-1-s]};
		end
	end

	// digit count and space check
	always_comb begin
		nd = CNT_W'(1);
		for (int d = 1; d < DIGITS; d++) begin
			if (bcd_q[d*4 +: 4] != 4'd0) begin
				nd = CNT_W'(d + 1);
			end
		end
		need = 8'(nd) + 8'd1 + {7'b0, neg_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			step_q  <= '0;
			shreg_q <= '0;
			bcd_q   <= '0;
			neg_q   <= 1'b0;
			cap_q   <= '0;
			ctrl_q  <= '0;
		end else begin
			unique case (state_q)
				F_IDLE: begin
					if (in_valid) begin
						shreg_q <= PAD_BITS'(mag);
						bcd_q   <= '0;
						neg_q   <= v_u[VALUE_BITS-1];
						cap_q   <= capacity;
						step_q  <= STEP_W'(STEPS - 1);
						state_q <= F_CONV;
					end
				end
				F_CONV: begin
					bcd_q   <= bcd_n;
					shreg_q <= shreg_q << STEP_BITS;
					if (step_q == '0) begin
						state_q <= F_CLASS;
					end else begin
						step_q <= step_q - 1'b1;
					end
				end
				F_CLASS: begin
					ctrl_q.err  <= (cap_q < need);
					ctrl_q.neg  <= neg_q;
					ctrl_q.ndig <= nd;
					state_q     <= F_PUSH;
				end
				F_PUSH: begin
					if (!full) begin
						state_q <= F_IDLE;
					end
				end
				default: state_q <= F_IDLE;
			endcase
		end
	end

	assign in_ready  = (state_q == F_IDLE);
	assign push      = (state_q == F_PUSH) && !full;
	assign push_bcd  = bcd_q;
	assign push_ctrl = ctrl_q;

endmodule
`default_nettype wire

>>> rtl/sdta_fifo.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sdta_fifo
// Short queue of classified items between the front and the back.
// ----------------------------------------------------------------------------
module sdta_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = sdta_pkg::QUEUE_DEPTH
) (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              push,
	input  wire  [WIDTH-1:0] wdata,
	output logic             full,
	input  wire              pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);
	import sdta_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_Q = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_q;
	logic [PTR_W-1:0] rd_q;
	logic [CNT_Q-1:0] cnt_q;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == PTR_W'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	assign rdata = mem_q[rd_q];
	assign full  = (cnt_q == CNT_Q'(DEPTH));
	assign empty = (cnt_q == '0);

endmodule
`default_nettype wire

>>> rtl/sdta_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sdta_back
// Takes classified items from the queue and emits the sign, the digits and
// the terminator, or the single error result, through an output register.
// ----------------------------------------------------------------------------
module sdta_back #(
	parameter int VALUE_BITS = sdta_pkg::VALUE_BITS_DEF
) (
	input  wire                                             clk,
	input  wire                                             arst_n,
	input  wire                                             empty,
	output logic                                            pop,
	input  wire  [sdta_pkg::digit_count(VALUE_BITS)*4-1:0]  pop_bcd,
	input  sdta_pkg::job_ctrl_t                             pop_ctrl,
	output logic                                            out_valid,
	input  wire                                             out_ready,
	output logic [6:0]                                      char_code,
	output logic                                            last,
	output logic                                            error
);
	import sdta_pkg::*;

	localparam int DIGITS = digit_count(VALUE_BITS);
	localparam int BCD_W  = DIGITS * 4;
	localparam int IDX_W  = $clog2(DIGITS);

	typedef enum logic [2:0] {B_IDLE, B_ERR, B_SIGN, B_DIG, B_TERM} bstate_t;

	bstate_t          state_q;
	logic [BCD_W-1:0] bcd_q;
	logic [IDX_W-1:0] idx_q;
	logic             out_valid_q;
	logic [6:0]       char_q;
	logic             last_q;
	logic             error_q;

	logic             ld;
	logic [3:0]       dig;
	logic [CNT_W-1:0] top_idx;

	assign ld      = !out_valid_q || out_ready;
	assign dig     = bcd_q[idx_q*4 +: 4];
	assign top_idx = pop_ctrl.ndig - 1'b1;
	assign pop     = (state_q == B_IDLE) && !empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_IDLE;
			bcd_q       <= '0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
			char_q      <= CHAR_NUL;
			last_q      <= 1'b0;
			error_q     <= 1'b0;
		end else begin
			unique case (state_q)
				B_IDLE: begin
					if (ld) begin
						out_valid_q <= 1'b0;
					end
					if (!empty) begin
						bcd_q <= pop_bcd;
						idx_q <= IDX_W'(top_idx);
						if (pop_ctrl.err) begin
							state_q <= B_ERR;
						end else if (pop_ctrl.neg) begin
							state_q <= B_SIGN;
						end else begin
							state_q <= B_DIG;
						end
					end
				end
				B_ERR: begin
					if (ld) begin
						out_valid_q <= 1'b1;
						char_q      <= CHAR_NUL;
						last_q      <= 1'b1;
						error_q     <= 1'b1;
						state_q     <= B_IDLE;
					end
				end
				B_SIGN: begin
					if (ld) begin
						out_valid_q <= 1'b1;
						char_q      <= CHAR_MINUS;
						last_q      <= 1'b0;
						error_q     <= 1'b0;
						state_q     <= B_DIG;
					end
				end
				B_DIG: begin
					if (ld) begin
						out_valid_q <= 1'b1;
						char_q      <= CHAR_ZERO + {3'b000, dig};
						last_q      <= 1'b0;
						error_q     <= 1'b0;
						if (idx_q == '0) begin
							state_q <= B_TERM;
						end else begin
							idx_q <= idx_q - 1'b1;
						end
					end
				end
				B_TERM: begin
					if (ld) begin
						out_valid_q <= 1'b1;
						char_q      <= CHAR_NUL;
						last_q      <= 1'b1;
						error_q     <= 1'b0;
						state_q     <= B_IDLE;
					end
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign char_code = char_q;
	assign last      = last_q;
	assign error     = error_q;

endmodule
`default_nettype wire

>>> rtl/signed_decimal_to_ascii_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// signed_decimal_to_ascii_unit
// Converts a signed integer to ascii decimal text, one character per item.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready): value and capacity. Output channel
// (out_valid/out_ready): char_code, last, error. Each input item yields an
// optional '-', the digits most significant first and a NUL with last set;
// if capacity cannot hold sign, digits and NUL, a single item with char_code
// 0, last 1 and error 1 is sent instead.
// The front converts the magnitude four bits a cycle (shift-add-3), then
// classifies the item and pushes it into the queue before it takes the next
// value. The back sends one character per cycle while out_ready is high,
// and fetches each item from the queue in its idle state before the first
// character of that item.
// A two-entry queue lets the front convert the next value while the back
// is still sending; when out_ready is low the back holds its output
// register and the queue fills, after which in_ready stays low.
// Reset clears all control state; no item is in flight after reset.
// ----------------------------------------------------------------------------
module signed_decimal_to_ascii_unit #(
	parameter int VALUE_BITS = sdta_pkg::VALUE_BITS_DEF
) (
	input  wire                         clk,
	input  wire                         arst_n,
	input  wire                         in_valid,
	output logic                        in_ready,
	input  wire signed [VALUE_BITS-1:0] value,
	input  wire        [7:0]            capacity,
	output logic                        out_valid,
	input  wire                         out_ready,
	output logic [6:0]                  char_code,
	output logic                        last,
	output logic                        error
);
	import sdta_pkg::*;

	localparam int BCD_W = digit_count(VALUE_BITS) * 4;
	localparam int ENT_W = BCD_W + $bits(job_ctrl_t);

	logic             q_push;
	logic             q_full;
	logic             q_pop;
	logic             q_empty;
	logic [BCD_W-1:0] f_bcd;
	job_ctrl_t        f_ctrl;
	logic [BCD_W-1:0] b_bcd;
	job_ctrl_t        b_ctrl;
	logic [ENT_W-1:0] q_wdata;
	logic [ENT_W-1:0] q_rdata;

	sdta_front #(
		.VALUE_BITS(VALUE_BITS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.value    (value),
		.capacity (capacity),
		.push     (q_push),
		.full     (q_full),
		.push_bcd (f_bcd),
		.push_ctrl(f_ctrl)
	);

	assign q_wdata = {f_ctrl, f_bcd};

	sdta_fifo #(
		.WIDTH(ENT_W),
		.DEPTH(QUEUE_DEPTH)
	) u_fifo (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (q_push),
		.wdata (q_wdata),
		.full  (q_full),
		.pop   (q_pop),
		.rdata (q_rdata),
		.empty (q_empty)
	);

	assign b_bcd  = q_rdata[BCD_W-1:0];
	assign b_ctrl = q_rdata[ENT_W-1:BCD_W];

	sdta_back #(
		.VALUE_BITS(VALUE_BITS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.empty    (q_empty),
		.pop      (q_pop),
		.pop_bcd  (b_bcd),
		.pop_ctrl (b_ctrl),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.char_code(char_code),
		.last     (last),
		.error    (error)
	);

`ifndef SYNTHESIS
	a_err_shape: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && error |-> last && (char_code == CHAR_NUL))
		else $error("error item without last or with a character");

	a_queue_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !q_full)
		else $error("queue written while full");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("front ready right after taking an item");

	a_pop_only_filled: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !q_empty)
		else $error("queue read while empty");
`endif

endmodule
`default_nettype wire

>>> verif/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the signed decimal to ascii unit. A directed table
// covers zero, the extremes, the smallest capacity that fits and the one just
// short of it. Random values of every digit count follow, in three rounds:
// mostly idle output, mostly idle input, then no idling. Each received
// character is checked against a queue of predicted characters.
// ----------------------------------------------------------------------------
module tb_top;
	import sdta_pkg::*;

	localparam int VB       = VALUE_BITS_DEF;
	localparam int DIR_ROWS = 24;
	localparam int RND_PER_PHASE = 117;

	typedef enum logic [1:0] {ROW_PREDICT, ROW_TEXT, ROW_ERROR} row_kind_t;

	typedef struct {
		logic signed [VB-1:0] val;
		logic [7:0]           cap;
		row_kind_t            kind;
	} dir_row_t;

	typedef struct packed {
		logic [6:0] code;
		logic       last;
		logic       err;
	} char_item_t;

	logic                 clk;
	logic                 arst_n    = 1'b0;
	logic                 in_valid  = 1'b0;
	logic                 in_ready;
	logic signed [VB-1:0] value     = '0;
	logic [7:0]           capacity  = '0;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	logic [6:0]           char_code;
	logic                 last;
	logic                 error;

	char_item_t exp_chars [$];
	int         fail_count   = 0;
	int         snd_idle_pct = 9;
	int         rcv_idle_pct = 78;

	dir_row_t dir_rows [0:DIR_ROWS-1] = '{
		'{32'sd0,           8'd2,   ROW_TEXT},
		'{32'sd0,           8'd1,   ROW_ERROR},
		'{32'sd0,           8'd0,   ROW_ERROR},
		'{-32'sd1,          8'd3,   ROW_TEXT},
		'{-32'sd1,          8'd2,   ROW_ERROR},
		'{32'sh7fffffff,    8'd11,  ROW_TEXT},
		'{32'sh7fffffff,    8'd10,  ROW_ERROR},
		'{32'sh80000000,    8'd12,  ROW_TEXT},
		'{32'sh80000000,    8'd11,  ROW_ERROR},
		'{32'sh80000000,    8'd255, ROW_TEXT},
		'{32'sh7fffffff,    8'd255, ROW_TEXT},
		'{32'sd9,           8'd2,   ROW_PREDICT},
		'{32'sd10,          8'd3,   ROW_PREDICT},
		'{32'sd10,          8'd2,   ROW_ERROR},
		'{-32'sd9,          8'd3,   ROW_PREDICT},
		'{-32'sd10,         8'd4,   ROW_PREDICT},
		'{32'sd99,          8'd3,   ROW_PREDICT},
		'{32'sd100,         8'd4,   ROW_PREDICT},
		'{32'sd999999999,   8'd10,  ROW_PREDICT},
		'{32'sd1000000000,  8'd11,  ROW_PREDICT},
		'{-32'sd1000000000, 8'd11,  ROW_ERROR},
		'{32'sd12345,       8'd0,   ROW_ERROR},
		'{32'sh55555555,    8'd255, ROW_PREDICT},
		'{32'shaaaaaaaa,    8'd128, ROW_PREDICT}
	};

	string dir_text [0:DIR_ROWS-1] = '{
		"0", "", "", "-1", "", "2147483647", "", "-2147483648", "",
		"-2147483648", "2147483647", "", "", "", "", "", "", "", "", "",
		"", "", "", ""
	};

	signed_decimal_to_ascii_unit #(
		.VALUE_BITS(VB)
	) DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.value    (value),
		.capacity (capacity),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.char_code(char_code),
		.last     (last),
		.error    (error)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// bytes needed for sign, digits and nul
	function automatic int text_need(input logic signed [VB-1:0] v);
		logic [VB-1:0] mag;
		int            nd;
		mag = v[VB-1] ? (~v + 1'b1) : v;
		nd  = 0;
		do begin
			nd++;
			mag = mag / 10;
		end while (mag != 0);
		return nd + 1 + (v[VB-1] ? 1 : 0);
	endfunction

	function automatic void predict_chars(input logic signed [VB-1:0] v,
			input logic [7:0] c);
		logic [VB-1:0] mag;
		logic [3:0]    digs [0:23];
		int            nd;
		mag = v[VB-1] ? (~v + 1'b1) : v;
		nd  = 0;
		if (int'(c) < text_need(v)) begin
			exp_chars.push_back('{CHAR_NUL, 1'b1, 1'b1});
			return;
		end
		do begin
			digs[nd] = 4'(mag % 10);
			nd++;
			mag = mag / 10;
		end while (mag != 0);
		if (v[VB-1])
			exp_chars.push_back('{CHAR_MINUS, 1'b0, 1'b0});
		for (int i = nd - 1; i >= 0; i--)
			exp_chars.push_back('{CHAR_ZERO + 7'(digs[i]), 1'b0, 1'b0});
		exp_chars.push_back('{CHAR_NUL, 1'b1, 1'b0});
	endfunction

	task automatic send_item(input logic signed [VB-1:0] v, input logic [7:0] c);
		while ($urandom_range(0, 99) < snd_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		value    <= v;
		capacity <= c;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
	endtask

	// output side: check each item, then pick next ready
	initial begin
		char_item_t want;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (out_valid && out_ready) begin
				if (exp_chars.size() == 0) begin
					$display("%0t: unexpected item code=%h last=%b error=%b",
						$time, char_code, last, error);
					fail_count++;
				end else begin
					want = exp_chars.pop_front();
					if (char_code !== want.code || last !== want.last ||
							error !== want.err) begin
						$display({"%0t: mismatch expected code=%h last=%b error=%b",
							" got code=%h last=%b error=%b"},
							$time, want.code, want.last, want.err,
							char_code, last, error);
						fail_count++;
					end
				end
			end
			out_ready <= ($urandom_range(0, 99) >= rcv_idle_pct);
		end
	end

	initial begin
		logic signed [VB-1:0] v;
		logic [7:0]           c;
		longint               lo;
		longint               hi;
		longint               mag;
		int                   k;
		int                   need;

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int r = 0; r < DIR_ROWS; r++) begin
			send_item(dir_rows[r].val, dir_rows[r].cap);
			case (dir_rows[r].kind)
				ROW_ERROR: begin
					exp_chars.push_back('{CHAR_NUL, 1'b1, 1'b1});
				end
				ROW_TEXT: begin
					for (int i = 0; i < dir_text[r].len(); i++)
						exp_chars.push_back('{7'(dir_text[r].getc(i)), 1'b0, 1'b0});
					exp_chars.push_back('{CHAR_NUL, 1'b1, 1'b0});
				end
				default: begin
					predict_chars(dir_rows[r].val, dir_rows[r].cap);
				end
			endcase
		end

		for (int phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin
					snd_idle_pct = 9;
					rcv_idle_pct = 78;
				end
				1: begin
					snd_idle_pct = 78;
					rcv_idle_pct = 9;
				end
				default: begin
					snd_idle_pct = 0;
					rcv_idle_pct = 0;
				end
			endcase
			repeat (RND_PER_PHASE) begin
				case ($urandom_range(0, 9))
					0: v = $urandom();
					1: begin
						case ($urandom_range(0, 3))
							0: v = 32'sh80000000 + $urandom_range(0, 3);
							1: v = 32'sh7fffffff - $urandom_range(0, 3);
							2: v = $urandom_range(0, 3);
							default: v = -$signed(32'($urandom_range(1, 4)));
						endcase
					end
					default: begin
						k  = $urandom_range(1, 10);
						lo = 1;
						for (int i = 1; i < k; i++)
							lo = lo * 10;
						hi = lo * 10 - 1;
						if (k == 1)
							lo = 0;
						if (hi > 64'd2147483647)
							hi = 64'd2147483647;
						mag = $urandom_range(32'(lo), 32'(hi));
						v   = $urandom_range(0, 1) ? -32'(mag) : 32'(mag);
					end
				endcase
				need = text_need(v);
				case ($urandom_range(0, 9))
					0, 1: c = $urandom_range(0, 255);
					2: c = 8'(need - 1);
					default: c = 8'(need + $urandom_range(0, 3));
				endcase
				send_item(v, c);
				predict_chars(v, c);
			end
		end

		in_valid <= 1'b0;
		while (exp_chars.size() != 0)
			@(posedge clk);
		repeat (30) @(posedge clk);
		if (fail_count == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("== FAIL ==");
		$finish;
	end

endmodule
